// ----- hdl/cllsg_pkg.sv -----
// ----------------------------------------------------------------------------
// cllsg_pkg
// Shared constants of the censored least-squares gradient engine.
// ----------------------------------------------------------------------------
`default_nettype none

package cllsg_pkg;

    // operation codes carried in the input tuser
    localparam logic [1:0] OP_WR_MATRIX  = 2'd0;
    localparam logic [1:0] OP_WR_MEASURE = 2'd1;
    localparam logic [1:0] OP_WR_WEIGHT  = 2'd2;
    localparam logic [1:0] OP_EVALUATE   = 2'd3;

    // relation codes
    localparam logic [1:0] REL_EQUAL = 2'd0;
    localparam logic [1:0] REL_LOWER = 2'd1;

    // result kinds carried in the output tuser
    localparam logic KIND_DIST = 1'b0;
    localparam logic KIND_GRAD = 1'b1;

    // configuration register indexes
    localparam logic CFG_ROWS = 1'b0;
    localparam logic CFG_COLS = 1'b1;

    localparam int ROWS_CFG_W = 9;
    localparam int COLS_CFG_W = 6;
    localparam int CFG_DATA_W = 9;
    localparam logic [ROWS_CFG_W-1:0] ROWS_RESET = 9'd256;
    localparam logic [COLS_CFG_W-1:0] COLS_RESET = 6'd32;

    // field widths
    localparam int ROW_W   = 8;
    localparam int COL_W   = 5;
    localparam int VAL_W   = 16;
    localparam int REL_W   = 2;
    localparam int INDEX_W = 5;
    localparam int DIST_W  = 63;
    localparam int GRAD_W  = 48;
    localparam int RES_W   = 40;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 120;

    // saturation bounds
    localparam logic signed [64:0] INNER_LIM  = 65'sh0_4000_0000_0000_0000;
    localparam logic signed [63:0] RES_MAX    = 64'sh0000_007F_FFFF_FFFF;
    localparam logic signed [63:0] RES_MIN    = 64'shFFFF_FF80_0000_0000;
    localparam logic signed [63:0] GRAD_MAX   = 64'sh0000_7FFF_FFFF_FFFF;
    localparam logic signed [63:0] GRAD_MIN   = 64'shFFFF_8000_0000_0000;
    localparam logic [64:0]        DIST_MAX   = 65'h0_7FFF_FFFF_FFFF_FFFF;
    localparam logic [RES_W-1:0]   SQ_LIMIT   = 40'd3037000499;
    localparam int                 SQ_SPLIT   = 20;

endpackage

`default_nettype wire

// ----- hdl/cllsg_ram.sv -----
// ----------------------------------------------------------------------------
// cllsg_ram
// Generic simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module cllsg_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                          clk,
    input  wire logic                          we,
    input  wire logic [ADDR_W-1:0]             waddr,
    input  wire logic [WIDTH-1:0]              wdata,
    input  wire logic                          re,
    input  wire logic [ADDR_W-1:0]             raddr,
    output      logic [WIDTH-1:0]              rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- hdl/censored_least_squares_loss_gradient.sv -----
// evaluate: a row pass for residuals and distance, then a column pass for the gradient,
// held by any output stall, on one shared multiplier and one matrix read port
// load items: one per cycle while idle; not ready during an evaluation
// reset: asynchronous active low; config returns to 256 rows and 32 columns,
// relations read as equal until written, other stores hold nothing valid
// ----------------------------------------------------------------------------
// censored_least_squares_loss_gradient
// Residual, squared distance and gradient engine over a stored fixed-point matrix.
// ----------------------------------------------------------------------------
`default_nettype none

module censored_least_squares_loss_gradient #(
    parameter int MAX_ROWS   = 256,
    parameter int MAX_COLS   = 32,
    parameter int VALUE_BITS = 16
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic                                cfg_index,
    input  wire logic [cllsg_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic                                s_axis_tvalid,
    output      logic                                s_axis_tready,
    // row, col, value, relation, zero pad
    input  wire logic [cllsg_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // operation
    input  wire logic [1:0]                          s_axis_tuser,
    output      logic                                m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // index, distance, gradient, zero pad
    output      logic [cllsg_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // kind
    output      logic [0:0]                          m_axis_tuser,
    output      logic                                m_axis_tlast
);

    localparam int RCW = $clog2(MAX_ROWS + 1);
    localparam int CCW = $clog2(MAX_COLS + 1);
    localparam int RIW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CIW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int MDEPTH = MAX_ROWS * MAX_COLS;
    localparam int MAW = (MDEPTH > 1) ? $clog2(MDEPTH) : 1;
    localparam int RW  = cllsg_pkg::RES_W;
    localparam int MUL_A_W = (VALUE_BITS > cllsg_pkg::SQ_SPLIT)
                           ? VALUE_BITS : cllsg_pkg::SQ_SPLIT + 1;
    localparam int MUL_B_W = RW + 1;
    localparam int PW = MUL_A_W + MUL_B_W;
    localparam int XW = ((PW > 64) ? PW : 64) + 1;

    typedef enum logic [3:0] {
        S_IDLE, S_ROW_START, S_P_RD, S_P_MUL, S_P_ACC, S_RES, S_SQ_LO, S_SQ_HI,
        S_SQ_ACC, S_DIST_OUT, S_COL_START, S_G_RD, S_G_MUL, S_G_ACC, S_GRAD_OUT,
        S_OUT_WAIT
    } state_t;

    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s > cllsg_pkg::INNER_LIM)
            s = cllsg_pkg::INNER_LIM;
        else if (s < -cllsg_pkg::INNER_LIM)
            s = -cllsg_pkg::INNER_LIM;
        return s[63:0];
    endfunction

    function automatic logic signed [63:0] sat_prod(input logic signed [PW-1:0] p);
        logic signed [XW-1:0] e;
        logic signed [XW-1:0] lim;
        e   = XW'(p);
        lim = XW'(cllsg_pkg::INNER_LIM);
        if (e > lim)
            e = lim;
        else if (e < -lim)
            e = -lim;
        return e[63:0];
    endfunction

    // input unpack
    logic [1:0]            in_op;
    logic [7:0]            in_row;
    logic [4:0]            in_col;
    logic [15:0]           in_value;
    logic [1:0]            in_rel;
    logic [VALUE_BITS-1:0] in_val_vb;
    logic                  in_acc;
    logic                  row_ok;
    logic                  col_ok;

    assign in_op     = s_axis_tuser;
    assign in_row    = s_axis_tdata[7:0];
    assign in_col    = s_axis_tdata[12:8];
    assign in_value  = s_axis_tdata[28:13];
    assign in_rel    = s_axis_tdata[30:29];
    assign in_val_vb = VALUE_BITS'(in_value);
    assign in_acc    = s_axis_tvalid && s_axis_tready;
    assign row_ok    = 32'(in_row) < MAX_ROWS;
    assign col_ok    = 32'(in_col) < MAX_COLS;

    state_t                 state_reg;
    logic [cllsg_pkg::ROWS_CFG_W-1:0] rows_cfg_reg;
    logic [cllsg_pkg::COLS_CFG_W-1:0] cols_cfg_reg;
    logic [RCW-1:0]         nr_reg;
    logic [CCW-1:0]         nc_reg;
    logic [RCW-1:0]         r_cnt_reg;
    logic [CCW-1:0]         c_cnt_reg;
    logic signed [63:0]     acc_reg;
    logic signed [63:0]     prod_reg;
    logic [64:0]            dist_reg;
    logic [RW-1:0]          mag_reg;
    logic                   big_reg;
    logic [63:0]            sq_lo_reg;
    logic [VALUE_BITS-1:0]  weight_reg [MAX_COLS];
    logic [MAX_ROWS-1:0]    rel_vld_reg;
    logic                   rel_vld_q_reg;
    logic                   out_valid_reg;
    logic                   out_kind_reg;
    logic [cllsg_pkg::INDEX_W-1:0] out_index_reg;
    logic [cllsg_pkg::DIST_W-1:0]  out_dist_reg;
    logic [cllsg_pkg::GRAD_W-1:0]  out_grad_reg;
    logic                   out_last_reg;

    logic [RIW-1:0]         r_idx;
    logic [CIW-1:0]         c_idx;
    assign r_idx = r_cnt_reg[RIW-1:0];
    assign c_idx = c_cnt_reg[CIW-1:0];

    // memories
    logic                   mat_we;
    logic [MAW-1:0]         mat_waddr;
    logic                   mat_re;
    logic [MAW-1:0]         mat_raddr;
    logic [VALUE_BITS-1:0]  mat_rdata;
    logic                   meas_we;
    logic                   row_re;
    logic [VALUE_BITS-1:0]  meas_rdata;
    logic [1:0]             rel_rdata;
    logic                   res_we;
    logic                   res_re;
    logic [RW-1:0]          res_rdata;
    logic [RW-1:0]          res_wdata;

    assign mat_we    = in_acc && in_op == cllsg_pkg::OP_WR_MATRIX && row_ok && col_ok;
    assign mat_waddr = MAW'(32'(RIW'(in_row)) * MAX_COLS + 32'(CIW'(in_col)));
    assign mat_re    = state_reg == S_P_RD || state_reg == S_G_RD;
    assign mat_raddr = MAW'(32'(r_idx) * MAX_COLS + 32'(c_idx));
    assign meas_we   = in_acc && in_op == cllsg_pkg::OP_WR_MEASURE && row_ok;
    assign row_re    = state_reg == S_ROW_START;
    assign res_re    = state_reg == S_G_RD;
    assign res_we    = state_reg == S_RES;

    cllsg_ram #(.WIDTH(VALUE_BITS), .DEPTH(MDEPTH)) u_matrix_ram (
        .clk(clk), .we(mat_we), .waddr(mat_waddr), .wdata(in_val_vb),
        .re(mat_re), .raddr(mat_raddr), .rdata(mat_rdata)
    );

    cllsg_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_ROWS)) u_measure_ram (
        .clk(clk), .we(meas_we), .waddr(RIW'(in_row)), .wdata(in_val_vb),
        .re(row_re), .raddr(r_idx), .rdata(meas_rdata)
    );

    cllsg_ram #(.WIDTH(2), .DEPTH(MAX_ROWS)) u_relation_ram (
        .clk(clk), .we(meas_we), .waddr(RIW'(in_row)), .wdata(in_rel),
        .re(row_re), .raddr(r_idx), .rdata(rel_rdata)
    );

    cllsg_ram #(.WIDTH(RW), .DEPTH(MAX_ROWS)) u_residual_ram (
        .clk(clk), .we(res_we), .waddr(r_idx), .wdata(res_wdata),
        .re(res_re), .raddr(r_idx), .rdata(res_rdata)
    );

    // shared multiplier operand select
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PW-1:0]      mul_p;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_P_MUL:
            begin
                mul_a = MUL_A_W'($signed(mat_rdata));
                mul_b = MUL_B_W'($signed(weight_reg[c_idx]));
            end
            S_G_MUL:
            begin
                mul_a = MUL_A_W'($signed(mat_rdata));
                mul_b = MUL_B_W'($signed(res_rdata));
            end
            S_SQ_LO:
            begin
                mul_a = MUL_A_W'(mag_reg[cllsg_pkg::SQ_SPLIT-1:0]);
                mul_b = MUL_B_W'(mag_reg);
            end
            S_SQ_HI:
            begin
                mul_a = MUL_A_W'(mag_reg[RW-1:cllsg_pkg::SQ_SPLIT]);
                mul_b = MUL_B_W'(mag_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = PW'(mul_a) * PW'(mul_b);

    // residual, censoring and square setup
    logic signed [63:0] meas_sh;
    logic signed [63:0] res_sum;
    logic signed [63:0] res_clamp;
    logic [1:0]         rel_eff;
    logic signed [63:0] res_mask;
    logic [RW-1:0]      res_mag;

    always_comb
    begin
        meas_sh   = 64'($signed(meas_rdata)) <<< 8;
        res_sum   = sat_add(acc_reg, -meas_sh);
        res_clamp = res_sum;
        if (res_sum > cllsg_pkg::RES_MAX)
            res_clamp = cllsg_pkg::RES_MAX;
        else if (res_sum < cllsg_pkg::RES_MIN)
            res_clamp = cllsg_pkg::RES_MIN;
        rel_eff  = rel_vld_q_reg ? rel_rdata : cllsg_pkg::REL_EQUAL;
        res_mask = res_clamp;
        if (rel_eff == cllsg_pkg::REL_LOWER)
        begin
            if (res_clamp > 0)
                res_mask = '0;
        end
        else if (rel_eff != cllsg_pkg::REL_EQUAL)
        begin
            if (res_clamp < 0)
                res_mask = '0;
        end
        res_mag = res_mask[63] ? RW'(-res_mask) : RW'(res_mask);
    end

    assign res_wdata = RW'(res_mask);

    // square accumulate and gradient clamp
    logic [64:0]        sq_val;
    logic [64:0]        dist_sum;
    logic signed [63:0] grad_clamp;

    always_comb
    begin
        sq_val = big_reg ? cllsg_pkg::DIST_MAX
                         : 65'(sq_lo_reg) + (65'(prod_reg) << cllsg_pkg::SQ_SPLIT);
        dist_sum = dist_reg + sq_val;
        if (dist_sum > cllsg_pkg::DIST_MAX)
            dist_sum = cllsg_pkg::DIST_MAX;
        grad_clamp = acc_reg;
        if (acc_reg > cllsg_pkg::GRAD_MAX)
            grad_clamp = cllsg_pkg::GRAD_MAX;
        else if (acc_reg < cllsg_pkg::GRAD_MIN)
            grad_clamp = cllsg_pkg::GRAD_MIN;
    end

    logic [RCW-1:0] r_inc;
    logic [CCW-1:0] c_inc;
    assign r_inc = r_cnt_reg + RCW'(1);
    assign c_inc = c_cnt_reg + CCW'(1);

    // weights and relation valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rel_vld_reg <= '0;
        end
        else if (meas_we)
        begin
            rel_vld_reg[RIW'(in_row)] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc && in_op == cllsg_pkg::OP_WR_WEIGHT && col_ok)
        begin
            weight_reg[CIW'(in_col)] <= in_val_vb;
        end
        if (row_re)
        begin
            rel_vld_q_reg <= rel_vld_reg[r_idx];
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rows_cfg_reg  <= cllsg_pkg::ROWS_RESET;
            cols_cfg_reg  <= cllsg_pkg::COLS_RESET;
            out_valid_reg <= 1'b0;
            out_kind_reg  <= cllsg_pkg::KIND_DIST;
            out_index_reg <= '0;
            out_dist_reg  <= '0;
            out_grad_reg  <= '0;
            out_last_reg  <= 1'b0;
            nr_reg        <= '0;
            nc_reg        <= '0;
            r_cnt_reg     <= '0;
            c_cnt_reg     <= '0;
            acc_reg       <= '0;
            prod_reg      <= '0;
            dist_reg      <= '0;
            mag_reg       <= '0;
            big_reg       <= 1'b0;
            sq_lo_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    cllsg_pkg::CFG_ROWS: rows_cfg_reg <= cfg_data;
                    cllsg_pkg::CFG_COLS: cols_cfg_reg <= cfg_data[cllsg_pkg::COLS_CFG_W-1:0];
                    default: ;
                endcase
            end
            prod_reg <= sat_prod(mul_p);
            case (state_reg)
                S_IDLE:
                begin
                    if (in_acc && in_op == cllsg_pkg::OP_EVALUATE)
                    begin
                        nr_reg    <= (32'(rows_cfg_reg) > MAX_ROWS) ? RCW'(MAX_ROWS)
                                                                   : RCW'(rows_cfg_reg);
                        nc_reg    <= (32'(cols_cfg_reg) > MAX_COLS) ? CCW'(MAX_COLS)
                                                                   : CCW'(cols_cfg_reg);
                        r_cnt_reg <= '0;
                        dist_reg  <= '0;
                        state_reg <= (rows_cfg_reg == '0) ? S_DIST_OUT : S_ROW_START;
                    end
                end
                S_ROW_START:
                begin
                    acc_reg   <= '0;
                    c_cnt_reg <= '0;
                    state_reg <= (nc_reg == '0) ? S_RES : S_P_RD;
                end
                S_P_RD:  state_reg <= S_P_MUL;
                S_P_MUL: state_reg <= S_P_ACC;
                S_P_ACC:
                begin
                    acc_reg   <= sat_add(acc_reg, prod_reg);
                    c_cnt_reg <= c_inc;
                    state_reg <= (c_inc == nc_reg) ? S_RES : S_P_RD;
                end
                S_RES:
                begin
                    mag_reg   <= res_mag;
                    big_reg   <= res_mag > cllsg_pkg::SQ_LIMIT;
                    state_reg <= S_SQ_LO;
                end
                S_SQ_LO: state_reg <= S_SQ_HI;
                S_SQ_HI:
                begin
                    sq_lo_reg <= prod_reg;
                    state_reg <= S_SQ_ACC;
                end
                S_SQ_ACC:
                begin
                    dist_reg  <= dist_sum;
                    r_cnt_reg <= r_inc;
                    state_reg <= (r_inc == nr_reg) ? S_DIST_OUT : S_ROW_START;
                end
                S_DIST_OUT:
                begin
                    out_valid_reg <= 1'b1;
                    out_kind_reg  <= cllsg_pkg::KIND_DIST;
                    out_index_reg <= '0;
                    out_dist_reg  <= dist_reg[cllsg_pkg::DIST_W-1:0];
                    out_grad_reg  <= '0;
                    out_last_reg  <= nc_reg == '0;
                    c_cnt_reg     <= '0;
                    state_reg     <= S_OUT_WAIT;
                end
                S_COL_START:
                begin
                    acc_reg   <= '0;
                    r_cnt_reg <= '0;
                    state_reg <= (nr_reg == '0) ? S_GRAD_OUT : S_G_RD;
                end
                S_G_RD:  state_reg <= S_G_MUL;
                S_G_MUL: state_reg <= S_G_ACC;
                S_G_ACC:
                begin
                    acc_reg   <= sat_add(acc_reg, prod_reg);
                    r_cnt_reg <= r_inc;
                    state_reg <= (r_inc == nr_reg) ? S_GRAD_OUT : S_G_RD;
                end
                S_GRAD_OUT:
                begin
                    out_valid_reg <= 1'b1;
                    out_kind_reg  <= cllsg_pkg::KIND_GRAD;
                    out_index_reg <= cllsg_pkg::INDEX_W'(c_cnt_reg);
                    out_dist_reg  <= '0;
                    out_grad_reg  <= grad_clamp[cllsg_pkg::GRAD_W-1:0];
                    out_last_reg  <= c_inc == nc_reg;
                    state_reg     <= S_OUT_WAIT;
                end
                S_OUT_WAIT:
                begin
                    if (m_axis_tready)
                    begin
                        out_valid_reg <= 1'b0;
                        if (out_last_reg)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            // distance item leaves column count at zero
                            if (out_kind_reg == cllsg_pkg::KIND_GRAD)
                                c_cnt_reg <= c_inc;
                            state_reg <= S_COL_START;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = state_reg == S_IDLE;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {4'b0, out_grad_reg, out_dist_reg, out_index_reg};

endmodule

`default_nettype wire

// ----- hdl/cllsg_checker.sv -----
// ----------------------------------------------------------------------------
// cllsg_checker
// Port-level checks of the censored least-squares gradient engine.
// ----------------------------------------------------------------------------
`default_nettype none

module cllsg_checker (
    input wire logic                             clk,
    input wire logic                             rst_n,
    input wire logic                             s_axis_tready,
    input wire logic                             m_axis_tvalid,
    input wire logic                             m_axis_tready,
    input wire logic [cllsg_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input wire logic [0:0]                       m_axis_tuser,
    input wire logic                             m_axis_tlast
);

    // one item at a time: no input taken while a result is pending
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input ready while result pending");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled result changed");

    a_dist_fields: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] == cllsg_pkg::KIND_DIST |->
            m_axis_tdata[4:0] == 5'd0 && m_axis_tdata[115:68] == 48'd0)
        else $error("distance item carries index or gradient");

    a_grad_fields: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] == cllsg_pkg::KIND_GRAD |->
            m_axis_tdata[67:5] == 63'd0)
        else $error("gradient item carries distance");

    // input stays closed until the last item of a run has left
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
            !s_axis_tready)
        else $error("run ended without last");

endmodule

bind censored_least_squares_loss_gradient cllsg_checker u_cllsg_checker (
    .clk(clk),
    .rst_n(rst_n),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast)
);

`default_nettype wire
